// ===== rtl/mieu_pkg.sv =====
`timescale 1ns / 1ps
package mieu_pkg;
  localparam logic [5:0] OP_ADD = 6'd0, OP_ADDI = 6'd1, OP_ADDIU = 6'd2, OP_ADDU = 6'd3,
    OP_AND = 6'd4, OP_ANDI = 6'd5, OP_BEQ = 6'd6, OP_BGEZ = 6'd7, OP_BGTZ = 6'd8,
    OP_BLEZ = 6'd9, OP_BLTZ = 6'd10, OP_BNE = 6'd11, OP_BREAK = 6'd12, OP_DIV = 6'd13,
    OP_J = 6'd14, OP_JAL = 6'd15, OP_JALR = 6'd16, OP_JR = 6'd17, OP_LB = 6'd18,
    OP_LBU = 6'd19, OP_LUI = 6'd20, OP_LW = 6'd21, OP_MFHI = 6'd22, OP_MFLO = 6'd23,
    OP_MULT = 6'd24, OP_OR = 6'd26, OP_ORI = 6'd27, OP_XOR = 6'd28,
    OP_SB = 6'd29, OP_SW = 6'd30, OP_SEB = 6'd31, OP_SLL = 6'd32, OP_SRA = 6'd33,
    OP_SRL = 6'd34, OP_SLT = 6'd35, OP_SLTI = 6'd36, OP_SLTIU = 6'd37, OP_SLTU = 6'd38,
    OP_SUB = 6'd39, OP_SUBU = 6'd40, OP_SYSCALL = 6'd41;

  localparam logic [1:0] ST_OK = 2'd0, ST_OVF = 2'd1, ST_BRK = 2'd2, ST_SYS = 2'd3;

  localparam logic [31:0] SEG_MASK = 32'hF000_0000;
  localparam logic [31:0] HALF_HIGH = 32'hFFFF_0000;
  localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
  localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;

  typedef struct packed {
    logic [5:0]  op;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic [15:0] immediate;
    logic [4:0]  shift_amount;
    logic [31:0] pc;
    logic [25:0] jump_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] result;
    logic        writes_result;
    logic        redirect;
    logic [31:0] target;
    logic [1:0]  status;
  } out_item_t;

  // start command into the multiply/divide unit and its completion
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [31:0] a;
    logic [31:0] b;
  } md_cmd_t;

  typedef struct packed {
    logic        done;
    logic        write_hilo;
    logic [31:0] hi;
    logic [31:0] lo;
  } md_rsp_t;
endpackage

// ===== rtl/mieu_if.sv =====
`timescale 1ns / 1ps
interface mieu_in_if;
  logic valid;
  logic ready;
  mieu_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mieu_out_if;
  logic valid;
  logic ready;
  mieu_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mieu_muldiv.sv =====
`timescale 1ns / 1ps
// shared 32-step shift/add-subtract unit: radix-2 multiply or restoring divide
module mieu_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  mieu_pkg::md_cmd_t cmd,
  output mieu_pkg::md_rsp_t rsp
);
  logic        busy;
  logic        done;
  logic [5:0]  count;
  logic        is_div;
  logic        neg_q;
  logic        neg_r;
  logic        zero_div;
  logic [31:0] mag_b;
  logic [31:0] acc;   // product high half or partial remainder
  logic [31:0] sh;    // multiplier / dividend, shifting out as quotient shifts in
  logic [32:0] diff;
  logic [32:0] psum;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [31:0] qf;
  logic [31:0] rf;

  assign ma = (cmd.is_div && cmd.a[31]) ? (32'd0 - cmd.a) : cmd.a;
  assign mb = (cmd.is_div && cmd.b[31]) ? (32'd0 - cmd.b) : cmd.b;
  assign diff = {acc, sh[31]} - {1'b0, mag_b};
  assign psum = {1'b0, acc} + (sh[0] ? {1'b0, mag_b} : 33'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start && !busy) begin
        busy <= 1'b1;
        count <= 6'd0;
      end else if (busy) begin
        count <= count + 6'd1;
        if (count == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start && !busy) begin
      is_div <= cmd.is_div;
      neg_q <= cmd.a[31] ^ cmd.b[31];
      neg_r <= cmd.a[31];
      zero_div <= (cmd.b == 32'd0);
      mag_b <= mb;
      acc <= 32'd0;
      sh <= ma;
    end else if (busy && count != 6'd32) begin
      if (is_div) begin
        if (!diff[32]) begin
          acc <= diff[31:0];
          sh <= {sh[30:0], 1'b1};
        end else begin
          acc <= {acc[30:0], sh[31]};
          sh <= {sh[30:0], 1'b0};
        end
      end else begin
        // unsigned multiply of raw operands, sign fix applied at the end
        acc <= psum[32:1];
        sh <= {psum[0], sh[31:1]};
      end
    end
  end

  // signed product high = unsigned high - (a<0 ? b : 0) - (b<0 ? a : 0)
  logic [31:0] a_raw;
  logic [31:0] b_raw;
  always_ff @(posedge clk) begin
    if (cmd.start && !busy) begin
      a_raw <= cmd.a;
      b_raw <= cmd.b;
    end
  end

  assign qf = neg_q ? (32'd0 - sh) : sh;
  assign rf = neg_r ? (32'd0 - acc) : acc;

  always_comb begin
    rsp.done = done;
    rsp.write_hilo = !(is_div && zero_div);
    if (is_div) begin
      rsp.hi = rf;
      rsp.lo = qf;
    end else begin
      rsp.hi = acc - (a_raw[31] ? b_raw : 32'd0) - (b_raw[31] ? a_raw : 32'd0);
      rsp.lo = sh;
    end
  end
endmodule

// ===== rtl/mips32_integer_execute_unit.sv =====
`timescale 1ns / 1ps
// MIPS32 integer execute stage.
// in: valid/ready channel carrying one instruction item (op, source values,
//   immediate, shift amount, pc, jump index). out: valid/ready channel that
//   carries one result item per instruction (result, writes_result, redirect,
//   target, status).
// Single-cycle ops have the result valid the cycle after accept. MULT and DIV
// run 32 steps on the shared shift/add-subtract unit and have the result valid
// after that unit reports done.
// One item is in flight at a time: in.ready is high only when the block is
// idle and the output register is empty.
// HI and LO live here; DIV by zero leaves them untouched.
// Reset (rst, synchronous) clears HI, LO, the sequencer and the output valid.
// When the receiver holds out.ready low, the result item stays in the output
// register unchanged and no new item is taken until it leaves.
module mips32_integer_execute_unit (
  input logic     clk,
  input logic     rst,
  mieu_in_if.sink in,
  mieu_out_if.source out
);
  localparam logic [1:0] S_IDLE = 2'd0, S_MD = 2'd1, S_OUT = 2'd2;

  logic [1:0] state;
  logic [31:0] hi_reg;
  logic [31:0] lo_reg;
  mieu_pkg::md_cmd_t md_cmd;
  mieu_pkg::md_rsp_t md_rsp;
  mieu_pkg::out_item_t res_next;
  mieu_pkg::out_item_t res;
  logic in_fire;

  logic [5:0] op;
  logic [31:0] a, b, simm, zimm, sum, dif, btarget, pc4;
  logic [31:0] sum_i;
  logic take;

  assign in.ready = (state == S_IDLE);
  assign in_fire = in.valid && in.ready;
  assign op = in.data.op;
  assign a = in.data.rs_value;
  assign b = in.data.rt_value;
  assign simm = {{16{in.data.immediate[15]}}, in.data.immediate};
  assign zimm = {16'd0, in.data.immediate};
  assign pc4 = in.data.pc + 32'd4;
  assign btarget = pc4 + {simm[29:0], 2'b00};
  assign dif = a - b;
  assign sum = a + ((op == mieu_pkg::OP_ADD) ? b : simm);
  assign sum_i = a + simm;

  assign md_cmd.start = in_fire && (op == mieu_pkg::OP_DIV || op == mieu_pkg::OP_MULT);
  assign md_cmd.is_div = (op == mieu_pkg::OP_DIV);
  assign md_cmd.a = a;
  assign md_cmd.b = b;

  mieu_muldiv u_md (.clk(clk), .rst(rst), .cmd(md_cmd), .rsp(md_rsp));

  always_comb begin
    res_next = '0;
    take = 1'b0;
    case (op)
      mieu_pkg::OP_ADD, mieu_pkg::OP_ADDI: begin
        if (((a ^ sum) & (((op == mieu_pkg::OP_ADD) ? b : simm) ^ sum)
            & mieu_pkg::SIGN_BIT) != 32'd0) begin
          res_next.status = mieu_pkg::ST_OVF;
        end else begin
          res_next.result = sum;
          res_next.writes_result = 1'b1;
        end
      end
      mieu_pkg::OP_SUB: begin
        if (((a ^ b) & (a ^ dif) & mieu_pkg::SIGN_BIT) != 32'd0) begin
          res_next.status = mieu_pkg::ST_OVF;
        end else begin
          res_next.result = dif;
          res_next.writes_result = 1'b1;
        end
      end
      mieu_pkg::OP_ADDIU: begin res_next.result = sum_i; res_next.writes_result = 1'b1; end
      mieu_pkg::OP_ADDU: begin res_next.result = a + b; res_next.writes_result = 1'b1; end
      mieu_pkg::OP_AND: begin res_next.result = a & b; res_next.writes_result = 1'b1; end
      mieu_pkg::OP_ANDI: begin res_next.result = a & zimm; res_next.writes_result = 1'b1; end
      mieu_pkg::OP_BEQ: take = (a == b);
      mieu_pkg::OP_BGEZ: take = !a[31];
      mieu_pkg::OP_BGTZ: take = !a[31] && (a != 32'd0);
      mieu_pkg::OP_BLEZ: take = a[31] || (a == 32'd0);
      mieu_pkg::OP_BLTZ: take = a[31];
      mieu_pkg::OP_BNE: take = (a != b);
      mieu_pkg::OP_BREAK: res_next.status = mieu_pkg::ST_BRK;
      mieu_pkg::OP_J, mieu_pkg::OP_JAL: begin
        res_next.redirect = 1'b1;
        res_next.target = (pc4 & mieu_pkg::SEG_MASK) | {4'd0, in.data.jump_index, 2'b00};
        if (op == mieu_pkg::OP_JAL) begin
          res_next.result = in.data.pc + 32'd8;
          res_next.writes_result = 1'b1;
        end
      end
      mieu_pkg::OP_JALR, mieu_pkg::OP_JR: begin
        res_next.redirect = 1'b1;
        res_next.target = a;
        if (op == mieu_pkg::OP_JALR) begin
          res_next.result = in.data.pc + 32'd8;
          res_next.writes_result = 1'b1;
        end
      end
      mieu_pkg::OP_LB, mieu_pkg::OP_LBU, mieu_pkg::OP_LW, mieu_pkg::OP_SB,
      mieu_pkg::OP_SW: res_next.result = sum_i;
      mieu_pkg::OP_LUI: begin
        res_next.result = {in.data.immediate, 16'd0};
        res_next.writes_result = 1'b1;
      end
      mieu_pkg::OP_MFHI: begin res_next.result = hi_reg; res_next.writes_result = 1'b1; end
      mieu_pkg::OP_MFLO: begin res_next.result = lo_reg; res_next.writes_result = 1'b1; end
      mieu_pkg::OP_OR: begin res_next.result = a | b; res_next.writes_result = 1'b1; end
      mieu_pkg::OP_ORI: begin res_next.result = a | zimm; res_next.writes_result = 1'b1; end
      mieu_pkg::OP_XOR: begin res_next.result = a ^ b; res_next.writes_result = 1'b1; end
      mieu_pkg::OP_SEB: begin
        res_next.result = b[7] ? ((b & mieu_pkg::BYTE_MASK) | ~mieu_pkg::BYTE_MASK)
                               : (b & mieu_pkg::BYTE_MASK);
        res_next.writes_result = 1'b1;
      end
      mieu_pkg::OP_SLL: begin
        res_next.result = b << in.data.shift_amount;
        res_next.writes_result = 1'b1;
      end
      mieu_pkg::OP_SRA: begin
        res_next.result = $unsigned($signed(b) >>> in.data.shift_amount);
        res_next.writes_result = 1'b1;
      end
      mieu_pkg::OP_SRL: begin
        res_next.result = b >> in.data.shift_amount;
        res_next.writes_result = 1'b1;
      end
      mieu_pkg::OP_SLT: begin
        res_next.result = {31'd0, ($signed(a) < $signed(b))};
        res_next.writes_result = 1'b1;
      end
      mieu_pkg::OP_SLTI: begin
        res_next.result = {31'd0, ($signed(a) < $signed(simm))};
        res_next.writes_result = 1'b1;
      end
      mieu_pkg::OP_SLTIU: begin res_next.result = {31'd0, (a < simm)}; res_next.writes_result = 1'b1; end
      mieu_pkg::OP_SLTU: begin res_next.result = {31'd0, (a < b)}; res_next.writes_result = 1'b1; end
      mieu_pkg::OP_SUBU: begin res_next.result = dif; res_next.writes_result = 1'b1; end
      mieu_pkg::OP_SYSCALL: res_next.status = mieu_pkg::ST_SYS;
      default: res_next = '0;
    endcase
    if (take) begin
      res_next.redirect = 1'b1;
      res_next.target = btarget;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hi_reg <= 32'd0;
      lo_reg <= 32'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) state <= md_cmd.start ? S_MD : S_OUT;
        end
        S_MD: begin
          if (md_rsp.done) begin
            state <= S_OUT;
            if (md_rsp.write_hilo) begin
              hi_reg <= md_rsp.hi;
              lo_reg <= md_rsp.lo;
            end
          end
        end
        S_OUT: begin
          if (out.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) res <= res_next;
  end

  assign out.valid = (state == S_OUT);
  assign out.data = res;

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> !in.ready) else $error("input taken while result pending");
  a_md_only_busy: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> state == S_MD) else $error("muldiv done outside wait");
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> $stable(res)) else $error("result changed while stalled");
endmodule

// ===== sim/tb_mips32_integer_execute_unit.sv =====
`timescale 1ns / 1ps
module tb_mips32_integer_execute_unit;
  logic clk;
  logic rst;

  mieu_in_if in_ch ();
  mieu_out_if out_ch ();

  mips32_integer_execute_unit dut (
    .clk(clk),
    .rst(rst),
    .in(in_ch.sink),
    .out(out_ch.source)
  );

  mieu_pkg::in_item_t pending_instrs[$];
  mieu_pkg::out_item_t expected_results[$];
  logic [31:0] model_hi;
  logic [31:0] model_lo;
  int error_count;
  int result_count;
  int accepted_count;
  bit no_idle;
  bit pause_send;
  bit long_hold;
  int send_gap;
  int recv_gap;
  int hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // computes the result of one instruction and updates hi/lo
  function automatic mieu_pkg::out_item_t execute_instr(input mieu_pkg::in_item_t it);
    mieu_pkg::out_item_t r;
    logic [31:0] a, b, simm, t, o, q, rm, ma, mb;
    logic [63:0] p;
    logic take;
    a = it.rs_value;
    b = it.rt_value;
    simm = sext16(it.immediate);
    r = '0;
    take = 1'b0;
    case (it.op)
      mieu_pkg::OP_ADD, mieu_pkg::OP_ADDI: begin
        o = (it.op == mieu_pkg::OP_ADD) ? b : simm;
        t = a + o;
        if (((a ^ t) & (o ^ t) & mieu_pkg::SIGN_BIT) != 0) r.status = mieu_pkg::ST_OVF;
        else begin
          r.result = t;
          r.writes_result = 1'b1;
        end
      end
      mieu_pkg::OP_SUB: begin
        t = a - b;
        if (((a ^ b) & (a ^ t) & mieu_pkg::SIGN_BIT) != 0) r.status = mieu_pkg::ST_OVF;
        else begin
          r.result = t;
          r.writes_result = 1'b1;
        end
      end
      mieu_pkg::OP_ADDIU: begin r.result = a + simm; r.writes_result = 1'b1; end
      mieu_pkg::OP_ADDU: begin r.result = a + b; r.writes_result = 1'b1; end
      mieu_pkg::OP_AND: begin r.result = a & b; r.writes_result = 1'b1; end
      mieu_pkg::OP_ANDI: begin
        r.result = a & {16'h0, it.immediate};
        r.writes_result = 1'b1;
      end
      mieu_pkg::OP_BEQ: take = (a == b);
      mieu_pkg::OP_BGEZ: take = !a[31];
      mieu_pkg::OP_BGTZ: take = !a[31] && a != 0;
      mieu_pkg::OP_BLEZ: take = a[31] || a == 0;
      mieu_pkg::OP_BLTZ: take = a[31];
      mieu_pkg::OP_BNE: take = (a != b);
      mieu_pkg::OP_BREAK: r.status = mieu_pkg::ST_BRK;
      mieu_pkg::OP_DIV: begin
        if (b != 0) begin
          ma = a[31] ? -a : a;
          mb = b[31] ? -b : b;
          q = ma / mb;
          rm = ma % mb;
          model_lo = (a[31] != b[31]) ? -q : q;
          model_hi = a[31] ? -rm : rm;
        end
      end
      mieu_pkg::OP_J, mieu_pkg::OP_JAL: begin
        r.redirect = 1'b1;
        r.target = ((it.pc + 32'd4) & mieu_pkg::SEG_MASK) | {4'h0, it.jump_index, 2'b00};
        if (it.op == mieu_pkg::OP_JAL) begin
          r.result = it.pc + 32'd8;
          r.writes_result = 1'b1;
        end
      end
      mieu_pkg::OP_JALR, mieu_pkg::OP_JR: begin
        r.redirect = 1'b1;
        r.target = a;
        if (it.op == mieu_pkg::OP_JALR) begin
          r.result = it.pc + 32'd8;
          r.writes_result = 1'b1;
        end
      end
      mieu_pkg::OP_LB, mieu_pkg::OP_LBU, mieu_pkg::OP_LW, mieu_pkg::OP_SB,
      mieu_pkg::OP_SW: r.result = a + simm;
      mieu_pkg::OP_LUI: begin r.result = {it.immediate, 16'h0}; r.writes_result = 1'b1; end
      mieu_pkg::OP_MFHI: begin r.result = model_hi; r.writes_result = 1'b1; end
      mieu_pkg::OP_MFLO: begin r.result = model_lo; r.writes_result = 1'b1; end
      mieu_pkg::OP_MULT: begin
        p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        model_hi = p[63:32];
        model_lo = p[31:0];
      end
      mieu_pkg::OP_OR: begin r.result = a | b; r.writes_result = 1'b1; end
      mieu_pkg::OP_ORI: begin
        r.result = a | {16'h0, it.immediate};
        r.writes_result = 1'b1;
      end
      mieu_pkg::OP_XOR: begin r.result = a ^ b; r.writes_result = 1'b1; end
      mieu_pkg::OP_SEB: begin r.result = {{24{b[7]}}, b[7:0]}; r.writes_result = 1'b1; end
      mieu_pkg::OP_SLL: begin r.result = b << it.shift_amount; r.writes_result = 1'b1; end
      mieu_pkg::OP_SRA: begin
        r.result = $signed(b) >>> it.shift_amount;
        r.writes_result = 1'b1;
      end
      mieu_pkg::OP_SRL: begin r.result = b >> it.shift_amount; r.writes_result = 1'b1; end
      mieu_pkg::OP_SLT: begin
        r.result = {31'h0, $signed(a) < $signed(b)};
        r.writes_result = 1'b1;
      end
      mieu_pkg::OP_SLTI: begin
        r.result = {31'h0, $signed(a) < $signed(simm)};
        r.writes_result = 1'b1;
      end
      mieu_pkg::OP_SLTIU: begin r.result = {31'h0, a < simm}; r.writes_result = 1'b1; end
      mieu_pkg::OP_SLTU: begin r.result = {31'h0, a < b}; r.writes_result = 1'b1; end
      mieu_pkg::OP_SUBU: begin r.result = a - b; r.writes_result = 1'b1; end
      mieu_pkg::OP_SYSCALL: r.status = mieu_pkg::ST_SYS;
      default: ;
    endcase
    if (take) begin
      r.redirect = 1'b1;
      r.target = it.pc + 32'd4 + {simm[29:0], 2'b00};
    end
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at result %0d: %s got %h want %h", result_count, field, got, want);
    error_count++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 15) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  function automatic mieu_pkg::in_item_t rand_instr();
    mieu_pkg::in_item_t it;
    it.op = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(42, 63))
                                         : 6'($urandom_range(0, 41));
    it.rs_value = rand_word();
    it.rt_value = ($urandom_range(0, 7) == 0) ? it.rs_value : rand_word();
    it.immediate = ($urandom_range(0, 3) == 0) ? 16'(rand_word()) : 16'($urandom);
    it.shift_amount = 5'($urandom);
    it.pc = $urandom;
    it.jump_index = 26'($urandom);
    return it;
  endfunction

  function automatic mieu_pkg::in_item_t make_instr(input logic [5:0] op,
                                                    input logic [31:0] a,
                                                    input logic [31:0] b,
                                                    input logic [15:0] imm);
    mieu_pkg::in_item_t it;
    it = rand_instr();
    it.op = op;
    it.rs_value = a;
    it.rt_value = b;
    it.immediate = imm;
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(execute_instr(in_ch.data));
        accepted_count++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the offered item
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pause_send || pending_instrs.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 10);
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.data <= pending_instrs.pop_front();
        in_ch.valid <= 1'b1;
      end
    end
  end

  // receiver idling
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_gap <= 0;
      hold_cycles <= 0;
    end else if (long_hold && hold_cycles < 300) begin
      hold_cycles <= hold_cycles + 1;
      out_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(0, 10);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk) begin
    mieu_pkg::out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("unexpected result item %h", out_ch.data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_ch.data.result !== want.result)
          report_mismatch("result", out_ch.data.result, want.result);
        if (out_ch.data.writes_result !== want.writes_result)
          report_mismatch("writes_result", 32'(out_ch.data.writes_result),
                          32'(want.writes_result));
        if (out_ch.data.redirect !== want.redirect)
          report_mismatch("redirect", 32'(out_ch.data.redirect), 32'(want.redirect));
        if (out_ch.data.target !== want.target)
          report_mismatch("target", out_ch.data.target, want.target);
        if (out_ch.data.status !== want.status)
          report_mismatch("status", 32'(out_ch.data.status), 32'(want.status));
      end
      result_count++;
    end
  end

  initial begin
    #40_000_000;
    $display("tb_mips32_integer_execute_unit: done, errors");
    $finish;
  end

  initial begin
    mieu_pkg::in_item_t it;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    model_hi = '0;
    model_lo = '0;
    error_count = 0;
    result_count = 0;
    accepted_count = 0;
    no_idle = 1'b0;
    pause_send = 1'b0;
    long_hold = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: hi/lo after reset, overflow edges, divide and multiply corners, other op corners, op codes 0 to 39
    pending_instrs.push_back(make_instr(mieu_pkg::OP_MFHI, 32'd0, 32'd0, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_MFLO, 32'd0, 32'd0, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_ADDI, 32'h8000_0000, 32'd0, 16'hFFFF));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_SUB, 32'h8000_0000, 32'd1, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                        16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF,
                                        16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_MFHI, 32'd0, 32'd0, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_MFLO, 32'd0, 32'd0, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_DIV, 32'd1234, 32'd0, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_MFLO, 32'd0, 32'd0, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_DIV, 32'hFFFF_FFF9, 32'd2, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_MFHI, 32'd0, 32'd0, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_MULT, 32'h8000_0000, 32'h8000_0000,
                                        16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_MFHI, 32'd0, 32'd0, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_SEB, 32'd0, 32'h0000_0080, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_SLTIU, 32'd5, 32'd0, 16'hFFFF));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_BEQ, 32'd3, 32'd3, 16'h8000));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_BGTZ, 32'd0, 32'd0, 16'h7FFF));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_BREAK, 32'd0, 32'd0, 16'd0));
    pending_instrs.push_back(make_instr(mieu_pkg::OP_SYSCALL, 32'd0, 32'd0, 16'd0));
    pending_instrs.push_back(make_instr(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
    it = make_instr(mieu_pkg::OP_SRA, 32'd0, 32'h8000_0000, 16'd0);
    it.shift_amount = 5'd31;
    pending_instrs.push_back(it);
    it.shift_amount = 5'd0;
    pending_instrs.push_back(it);
    it = make_instr(mieu_pkg::OP_JAL, 32'd0, 32'd0, 16'd0);
    it.pc = 32'hFFFF_FFFC;
    it.jump_index = 26'h3FF_FFFF;
    pending_instrs.push_back(it);
    for (int i = 0; i < 40; i++)
      pending_instrs.push_back(make_instr(6'(i), 32'd0, 32'd0, 16'd0));

    for (int i = 0; i < 500; i++) pending_instrs.push_back(rand_instr());
    wait (pending_instrs.size() == 0);
    // sender pause until everything has drained
    pause_send = 1'b1;
    wait (expected_results.size() == 0 && !in_ch.valid);
    pause_send = 1'b0;

    // long receiver hold while items keep being offered
    long_hold = 1'b1;
    for (int i = 0; i < 600; i++) pending_instrs.push_back(rand_instr());
    wait (pending_instrs.size() == 0);
    long_hold = 1'b0;
    wait (in_ch.valid == 1'b0 || in_ch.ready);
    no_idle = 1'b1;
    for (int i = 0; i < 400; i++) pending_instrs.push_back(rand_instr());
    wait (pending_instrs.size() == 0);
    @(posedge clk);
    wait (!in_ch.valid);
    wait (expected_results.size() == 0);
    repeat (40) @(posedge clk);

    $display("covered %0d accepted instructions over all opcodes plus unknown codes,",
             accepted_count);
    $display("%0d results checked, with hi/lo tracking, overflow and stall phases",
             result_count);
    if (error_count == 0) begin
      $display("tb_mips32_integer_execute_unit: done, clean");
    end else begin
      $display("tb_mips32_integer_execute_unit: done, errors");
    end
    $finish;
  end
endmodule
